/* rtl/key_frequency_table_min_max_assert.svh */
// Assertion macros used by the key frequency table top level.
`ifndef KEY_FREQUENCY_TABLE_MIN_MAX_ASSERT_SVH
`define KEY_FREQUENCY_TABLE_MIN_MAX_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define KFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define KFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/kft_pkg.sv */
// Shared types and constants of the key frequency table.
package kft_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
   localparam int KEY_BITS      = 32;
   localparam int COUNT_BITS    = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE  = {{(COUNT_BITS-1){1'b0}}, 1'b1};
   localparam logic [COUNT_BITS-1:0] COUNT_ZERO = {COUNT_BITS{1'b0}};
   localparam logic [SLOT_BITS-1:0]  LAST_SLOT  = SLOT_BITS'(TABLE_ENTRIES - 1);
   localparam logic [SLOT_BITS:0]    ISSUE_END  = (SLOT_BITS+1)'(TABLE_ENTRIES);

   // Command codes
   localparam logic CMD_INC = 1'b0;
   localparam logic CMD_DEC = 1'b1;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;

   // One stored slot: key and its count
   typedef struct packed {
      key_type   key;
      count_type count;
   } kft_entry_type;

   // One candidate offered to the min/max tracker
   typedef struct packed {
      logic      vld;
      slot_type  slot;
      key_type   key;
      count_type count;
   } kft_cand_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_REPLY  = 4'b1000
   } kft_state_type;

endpackage

/* rtl/kft_slot_ram.sv */
// Slot memory holding key and count, one write and one registered read port.
module kft_slot_ram (
   input  logic                  clock,
   input  logic                  rd_en,
   input  kft_pkg::slot_type     rd_addr,
   output kft_pkg::kft_entry_type rd_data,
   input  logic                  wr_en,
   input  kft_pkg::slot_type     wr_addr,
   input  kft_pkg::kft_entry_type wr_data
);
   import kft_pkg::*;

   kft_entry_type mem_ff [TABLE_ENTRIES];
   kft_entry_type rd_data_ff;

   // Write the addressed slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/kft_scan.sv */
// Running min/max tracker: one candidate per cycle, ties go to the lower slot.
module kft_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  kft_pkg::kft_cand_type cand,
   output logic                 any_keys,
   output kft_pkg::key_type     hi_key,
   output kft_pkg::key_type     lo_key
);
   import kft_pkg::*;

   logic      any_ff,     any_in;
   count_type hi_cnt_ff,  hi_cnt_in;
   slot_type  hi_slot_ff, hi_slot_in;
   key_type   hi_key_ff,  hi_key_in;
   count_type lo_cnt_ff,  lo_cnt_in;
   slot_type  lo_slot_ff, lo_slot_in;
   key_type   lo_key_ff,  lo_key_in;

   logic hi_win;
   logic lo_win;

   // Compare the candidate against the current extremes
   always_comb begin
      hi_win = cand.vld && (!any_ff || (cand.count > hi_cnt_ff) ||
               ((cand.count == hi_cnt_ff) && (cand.slot < hi_slot_ff)));
      lo_win = cand.vld && (!any_ff || (cand.count < lo_cnt_ff) ||
               ((cand.count == lo_cnt_ff) && (cand.slot < lo_slot_ff)));

      any_in     = any_ff | cand.vld;
      hi_cnt_in  = hi_cnt_ff;
      hi_slot_in = hi_slot_ff;
      hi_key_in  = hi_key_ff;
      lo_cnt_in  = lo_cnt_ff;
      lo_slot_in = lo_slot_ff;
      lo_key_in  = lo_key_ff;

      if (hi_win) begin
         hi_cnt_in  = cand.count;
         hi_slot_in = cand.slot;
         hi_key_in  = cand.key;
      end
      if (lo_win) begin
         lo_cnt_in  = cand.count;
         lo_slot_in = cand.slot;
         lo_key_in  = cand.key;
      end
      if (clear) begin
         any_in = 1'b0;
      end
   end

   // Hold the valid flag under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else begin
         any_ff <= any_in;
      end
   end

   // Advance the extremes
   always_ff @(posedge clock) begin
      hi_cnt_ff  <= hi_cnt_in;
      hi_slot_ff <= hi_slot_in;
      hi_key_ff  <= hi_key_in;
      lo_cnt_ff  <= lo_cnt_in;
      lo_slot_ff <= lo_slot_in;
      lo_key_ff  <= lo_key_in;
   end

   assign any_keys = any_ff;
   assign hi_key   = hi_key_ff;
   assign lo_key   = lo_key_ff;

endmodule

/* rtl/key_frequency_table_min_max.sv */
// Key frequency table with highest and lowest count report, top level.
//
// Usage:
//   Input transaction (req_valid/req_stall): req_command 0 increments the
//   count of req_key, 1 decrements it. A new key takes the lowest free slot;
//   a count reaching zero frees its slot. The block stalls req_ while it
//   works on one transaction.
//   Result transaction (rsp_valid/rsp_stall): one per input, with has_keys,
//   the keys of highest and lowest count (lowest slot on ties), the touched
//   key's count and the table_full / saturated flags.
//   Sequence: each transaction reads all 64 slots once through the single
//   read port of the slot memory, applying the update and tracking min/max
//   on the fly; then the finish step writes back the slot and the reply step
//   loads the result register. A new transaction is taken only after the
//   reply step, once the block is back in idle.
//   A stalled result holds in the output register; the next transaction is
//   accepted meanwhile and waits at its reply step until the register frees.
//   Reset clears all valid marks at once; no clearing pass is needed.
module key_frequency_table_min_max (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  kft_pkg::key_type  req_key,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_has_keys,
   output kft_pkg::key_type  rsp_max_key,
   output kft_pkg::key_type  rsp_min_key,
   output kft_pkg::count_type rsp_key_count,
   output logic              rsp_table_full,
   output logic              rsp_saturated
);
   import kft_pkg::*;
   `include "key_frequency_table_min_max_assert.svh"

   kft_state_type state_ff, state_in;

   logic                   cmd_ff,        cmd_in;
   key_type                key_ff,        key_in;
   logic [SLOT_BITS:0]     issue_ff,      issue_in;
   logic                   chk_vld_ff,    chk_vld_in;
   slot_type               chk_slot_ff,   chk_slot_in;
   logic [TABLE_ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic                   match_ff,      match_in;
   slot_type               match_slot_ff, match_slot_in;
   count_type              new_cnt_ff,    new_cnt_in;
   logic                   drop_ff,       drop_in;
   logic                   sat_ff,        sat_in;
   logic                   free_ff,       free_in;
   slot_type               free_slot_ff,  free_slot_in;

   logic                   rsp_valid_ff,     rsp_valid_in;
   logic                   rsp_has_keys_ff,  rsp_has_keys_in;
   key_type                rsp_max_key_ff,   rsp_max_key_in;
   key_type                rsp_min_key_ff,   rsp_min_key_in;
   count_type              rsp_key_count_ff, rsp_key_count_in;
   logic                   rsp_full_ff,      rsp_full_in;
   logic                   rsp_sat_ff,       rsp_sat_in;

   logic          req_take;
   logic          rsp_take;
   logic          out_free;
   logic          rd_en;
   kft_entry_type rd_data;
   logic          wr_en;
   slot_type      wr_addr;
   kft_entry_type wr_data;
   logic          cur_valid;
   logic          hit;
   logic          at_max;
   count_type     upd_cnt;
   logic          upd_drop;
   logic          alloc;
   logic          scan_clear;
   kft_cand_type  cand;
   logic          any_keys;
   key_type       hi_key;
   key_type       lo_key;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Decode the slot under check
   always_comb begin
      cur_valid = slot_valid_ff[chk_slot_ff];
      hit       = chk_vld_ff && cur_valid && (rd_data.key == key_ff);
      at_max    = (rd_data.count == COUNT_MAX);
      upd_drop  = (cmd_ff == CMD_DEC) && (rd_data.count <= COUNT_ONE);
      if (cmd_ff == CMD_INC) begin
         upd_cnt = at_max ? rd_data.count : rd_data.count + COUNT_ONE;
      end else begin
         upd_cnt = rd_data.count - COUNT_ONE;
      end
      alloc = (cmd_ff == CMD_INC) && !match_ff && free_ff;
   end

   // Select the candidate for the tracker: scanned slot or newly taken slot
   always_comb begin
      if (state_ff == ST_FINISH) begin
         cand.vld   = alloc;
         cand.slot  = free_slot_ff;
         cand.key   = key_ff;
         cand.count = COUNT_ONE;
      end else begin
         cand.vld   = chk_vld_ff && cur_valid && !(hit && upd_drop);
         cand.slot  = chk_slot_ff;
         cand.key   = rd_data.key;
         cand.count = hit ? upd_cnt : rd_data.count;
      end
   end

   // Sequence one transaction: scan, write back, reply
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_slot_in   = issue_ff[SLOT_BITS-1:0];
      slot_valid_in = slot_valid_ff;
      match_in      = match_ff;
      match_slot_in = match_slot_ff;
      new_cnt_in    = new_cnt_ff;
      drop_in       = drop_ff;
      sat_in        = sat_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = match_ff ? match_slot_ff : free_slot_ff;
      wr_data.key   = key_ff;
      wr_data.count = match_ff ? new_cnt_ff : COUNT_ONE;
      scan_clear    = 1'b0;

      rsp_valid_in     = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_has_keys_in  = rsp_has_keys_ff;
      rsp_max_key_in   = rsp_max_key_ff;
      rsp_min_key_in   = rsp_min_key_ff;
      rsp_key_count_in = rsp_key_count_ff;
      rsp_full_in      = rsp_full_ff;
      rsp_sat_in       = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in     = req_command;
               key_in     = req_key;
               issue_in   = '0;
               match_in   = 1'b0;
               drop_in    = 1'b0;
               sat_in     = 1'b0;
               free_in    = 1'b0;
               scan_clear = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue the next slot read
            if (issue_ff < ISSUE_END) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               issue_in   = issue_ff + 1'b1;
            end
            // note the key's slot and the first free slot
            if (hit) begin
               match_in      = 1'b1;
               match_slot_in = chk_slot_ff;
               new_cnt_in    = upd_cnt;
               drop_in       = upd_drop;
               sat_in        = (cmd_ff == CMD_INC) && at_max;
            end
            if (chk_vld_ff && !cur_valid && !free_ff) begin
               free_in      = 1'b1;
               free_slot_in = chk_slot_ff;
            end
            if (chk_vld_ff && (chk_slot_ff == LAST_SLOT)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // write back the touched slot, or free it if its count dropped to zero
            if (match_ff) begin
               wr_en = !drop_ff;
               if (drop_ff) begin
                  slot_valid_in[match_slot_ff] = 1'b0;
               end
            end else if (alloc) begin
               wr_en = 1'b1;
               slot_valid_in[free_slot_ff] = 1'b1;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_has_keys_in  = any_keys;
               rsp_max_key_in   = any_keys ? hi_key : '0;
               rsp_min_key_in   = any_keys ? lo_key : '0;
               rsp_full_in      = (cmd_ff == CMD_INC) && !match_ff && !free_ff;
               rsp_sat_in       = match_ff && sat_ff;
               if (match_ff) begin
                  rsp_key_count_in = drop_ff ? COUNT_ZERO : new_cnt_ff;
               end else begin
                  rsp_key_count_in = alloc ? COUNT_ONE : COUNT_ZERO;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Advance the payload registers
   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      key_ff           <= key_in;
      issue_ff         <= issue_in;
      chk_slot_ff      <= chk_slot_in;
      match_ff         <= match_in;
      match_slot_ff    <= match_slot_in;
      new_cnt_ff       <= new_cnt_in;
      drop_ff          <= drop_in;
      sat_ff           <= sat_in;
      free_ff          <= free_in;
      free_slot_ff     <= free_slot_in;
      rsp_has_keys_ff  <= rsp_has_keys_in;
      rsp_max_key_ff   <= rsp_max_key_in;
      rsp_min_key_ff   <= rsp_min_key_in;
      rsp_key_count_ff <= rsp_key_count_in;
      rsp_full_ff      <= rsp_full_in;
      rsp_sat_ff       <= rsp_sat_in;
   end

   kft_slot_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[SLOT_BITS-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   kft_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (scan_clear),
      .cand     (cand),
      .any_keys (any_keys),
      .hi_key   (hi_key),
      .lo_key   (lo_key)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_keys   = rsp_has_keys_ff;
   assign rsp_max_key    = rsp_max_key_ff;
   assign rsp_min_key    = rsp_min_key_ff;
   assign rsp_key_count  = rsp_key_count_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_saturated  = rsp_sat_ff;

   `KFT_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_take, state_ff == ST_SCAN, "accepted transaction did not start a scan")
   `KFT_ASSERT_NOW(a_result_from_reply, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_REPLY), "result appeared outside the reply step")
   `KFT_ASSERT_NOW(a_finish_after_last, clock, reset, state_ff == ST_FINISH, $past(chk_vld_ff && (chk_slot_ff == LAST_SLOT)), "write back before the last slot was checked")
   `KFT_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_valid_ff, !(rsp_full_ff && rsp_sat_ff), "table_full and saturated both set")
   `KFT_ASSERT_NOW(a_empty_keys_zero, clock, reset, rsp_valid_ff && !rsp_has_keys_ff, (rsp_max_key_ff == '0) && (rsp_min_key_ff == '0), "empty table reported nonzero keys")

endmodule
